FILE: rtl/accel_shock_detector_defines.svh
// Assertion macros for the shock detector
`ifndef ACCEL_SHOCK_DETECTOR_DEFINES_SVH
`define ACCEL_SHOCK_DETECTOR_DEFINES_SVH

// same-cycle implication, checked outside reset
`define ASD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define ASD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/asd_pkg.sv
// Shared types and constants for the shock detector
package asd_pkg;

    localparam int SAMPLE_W     = 16;
    localparam int THR_W        = 8;
    localparam int AXES         = 3;
    localparam int COUNT_W      = 2;
    localparam logic [THR_W-1:0]   THR_RESET    = 8'd70;
    localparam logic [COUNT_W-1:0] COUNT_ALL    = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_AVG,
        S_MERGE
    } t_state;

    typedef struct packed {
        logic load;
        logic primed;
        logic mul_en;
        logic avg_en;
        logic base_load;
    } t_lane_ctrl;

    typedef struct packed {
        logic base_load;
        logic motion;
        logic lock;
    } t_merge_res;

endpackage

FILE: rtl/asd_lane.sv
// One axis lane: sample ring, running sum, divide by depth, baseline compare
module asd_lane
    import asd_pkg::*;
#(
    parameter int AVG_DEPTH = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_lane_ctrl                 i_ctrl,
    input  logic [((AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1)-1:0] i_ptr,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic [THR_W-1:0]           i_threshold,
    output logic signed [SAMPLE_W-1:0] o_avg,
    output logic                       o_over,
    output logic                       o_base_zero
);

    localparam int PW    = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
    localparam int L     = $clog2(AVG_DEPTH);
    localparam int SW    = SAMPLE_W + L;
    localparam int SH    = SW + L;
    localparam int MW    = SH + 1;
    localparam int PRW   = SW + MW;
    localparam logic [MW-1:0] RECIP =
        MW'(((64'd1 << SH) + 64'(AVG_DEPTH) - 64'd1) / 64'(AVG_DEPTH));
    localparam logic signed [SW-1:0] DEPTH_S = SW'(AVG_DEPTH);

    logic signed [SAMPLE_W-1:0] r_ring [AVG_DEPTH];
    logic signed [SAMPLE_W-1:0] n_ring [AVG_DEPTH];
    logic signed [SW-1:0]       r_sum;
    logic signed [SW-1:0]       n_sum;
    logic                       r_neg;
    logic [PRW-1:0]             r_prod;
    logic [SW-1:0]              w_mag;
    logic [SW-1:0]              w_quo;
    logic [SW-1:0]              w_avg_full;
    logic signed [SAMPLE_W-1:0] r_avg;
    logic signed [SAMPLE_W-1:0] r_base;
    logic signed [SAMPLE_W:0]   w_diff;
    logic [SAMPLE_W:0]          w_dmag;

    always_comb begin
        for (int k = 0; k < AVG_DEPTH; k++) begin
            n_ring[k] = (!i_ctrl.primed || (i_ptr == PW'(k))) ? i_sample : r_ring[k];
        end
        if (i_ctrl.primed) begin
            n_sum = r_sum - SW'(r_ring[i_ptr]) + SW'(i_sample);
        end else begin
            n_sum = SW'(i_sample) * DEPTH_S;
        end
    end

    assign w_mag      = r_sum[SW-1] ? SW'(-r_sum) : SW'(r_sum);
    assign w_quo      = r_prod[SH +: SW];
    assign w_avg_full = r_neg ? (~w_quo + SW'(1)) : w_quo;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_ring <= n_ring;
            r_sum  <= n_sum;
        end
        if (i_ctrl.mul_en) begin
            r_neg  <= r_sum[SW-1];
            r_prod <= PRW'(w_mag) * PRW'(RECIP);
        end
        if (i_ctrl.avg_en) begin
            r_avg <= signed'(w_avg_full[SAMPLE_W-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
        end else if (i_ctrl.base_load) begin
            r_base <= r_avg;
        end
    end

    assign w_diff      = (SAMPLE_W+1)'(r_base) - (SAMPLE_W+1)'(r_avg);
    assign w_dmag      = w_diff[SAMPLE_W] ? unsigned'(-w_diff) : unsigned'(w_diff);
    assign o_over      = w_dmag > (SAMPLE_W+1)'(i_threshold);
    assign o_base_zero = (r_base == '0);
    assign o_avg       = r_avg;

endmodule

FILE: rtl/asd_merge.sv
// Merge of lane results: count rule, charger edge skip and lock decision
module asd_merge
    import asd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  logic             i_commit,
    input  logic             i_charger,
    input  logic             i_armed,
    input  logic [AXES-1:0]  i_over,
    input  logic [AXES-1:0]  i_base_zero,
    output t_merge_res       o_res
);

    logic               r_chg_prev;
    logic               r_skip;
    logic               r_armed;
    logic [COUNT_W-1:0] w_count;
    logic               w_reject;
    logic               w_consume;

    always_comb begin
        w_count = COUNT_W'(i_over[0]) + COUNT_W'(i_over[1]) + COUNT_W'(i_over[2]);
        w_reject = i_over[2] && (w_count < COUNT_ALL);
        if (|i_base_zero) begin
            o_res.base_load = 1'b1;
            o_res.motion    = 1'b0;
        end else begin
            o_res.base_load = !w_reject;
            o_res.motion    = !w_reject && (w_count != '0);
        end
        o_res.lock = o_res.motion && r_armed && !r_skip;
        w_consume  = o_res.motion && r_armed && r_skip;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chg_prev <= 1'b0;
            r_skip     <= 1'b0;
            r_armed    <= 1'b0;
        end else if (i_load) begin
            r_armed <= i_armed;
            if (i_charger != r_chg_prev) begin
                r_chg_prev <= i_charger;
                r_skip     <= 1'b1;
            end
        end else if (i_commit && w_consume) begin
            r_skip <= 1'b0;
        end
    end

endmodule

FILE: rtl/accel_shock_detector.sv
// Top level of the accelerometer shock detector
//
// Input channel: i_in_valid with o_in_stall; a request carries one X/Y/Z
// sample plus the charger level and the recording-armed flag.
// Output channel: o_out_valid with i_out_stall; one result per request with
// the three moving averages, the motion flag and the lock request.
// Configuration: i_cfg_valid/o_cfg_ready with i_cfg_data sets the motion
// threshold; write it only while no request is in flight.
// Three axis lanes run side by side; each keeps its ring of AVG_DEPTH
// samples and a running sum, then divides by the depth with a reciprocal
// multiply. A merge stage applies the count rule and the lock decision.
// An accepted request passes through the sum, multiply, average and merge
// steps of the shared sequencer; a new request is taken only after the merge
// step, and the block holds o_in_stall high while a request is in flight.
// When the receiver stalls, the result waits in the output register; a
// following request is still taken and runs up to its merge step, where it
// waits until the output register frees.
// Reset clears the ring pointer, priming flag, baselines, charger state,
// pending skip and threshold (70); the ring is refilled by the first sample.
// Both the input and the configuration channel hold off while in reset.
module accel_shock_detector
    import asd_pkg::*;
#(
    parameter int AVG_DEPTH = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic signed [SAMPLE_W-1:0] i_accel_x,
    input  logic signed [SAMPLE_W-1:0] i_accel_y,
    input  logic signed [SAMPLE_W-1:0] i_accel_z,
    input  logic                       i_charger_present,
    input  logic                       i_recording_armed,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic signed [SAMPLE_W-1:0] o_avg_x,
    output logic signed [SAMPLE_W-1:0] o_avg_y,
    output logic signed [SAMPLE_W-1:0] o_avg_z,
    output logic                       o_motion_detected,
    output logic                       o_lock_request,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [THR_W-1:0]           i_cfg_data
);

`include "accel_shock_detector_defines.svh"

    localparam int PW = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;

    t_state                     r_state;
    t_state                     n_state;
    logic [PW-1:0]              r_ptr;
    logic                       r_primed;
    logic [THR_W-1:0]           r_threshold;
    logic                       w_in_accept;
    logic                       w_commit;
    t_lane_ctrl                 w_ctrl;
    t_merge_res                 w_res;
    logic signed [SAMPLE_W-1:0] w_samples [AXES];
    logic signed [SAMPLE_W-1:0] w_avgs    [AXES];
    logic [AXES-1:0]            w_over;
    logic [AXES-1:0]            w_base_zero;
    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_avg_x;
    logic signed [SAMPLE_W-1:0] r_avg_y;
    logic signed [SAMPLE_W-1:0] r_avg_z;
    logic                       r_motion;
    logic                       r_lock;

    assign w_samples[0] = i_accel_x;
    assign w_samples[1] = i_accel_y;
    assign w_samples[2] = i_accel_z;

    assign o_in_stall  = !i_rst_n || (r_state != S_IDLE);
    assign o_cfg_ready = i_rst_n;
    assign w_in_accept = i_in_valid && !o_in_stall;
    assign w_commit    = (r_state == S_MERGE) && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state          = r_state;
        w_ctrl.load      = 1'b0;
        w_ctrl.primed    = r_primed;
        w_ctrl.mul_en    = 1'b0;
        w_ctrl.avg_en    = 1'b0;
        w_ctrl.base_load = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    w_ctrl.load = 1'b1;
                    n_state     = S_DIV;
                end
            end
            S_DIV: begin
                w_ctrl.mul_en = 1'b1;
                n_state       = S_AVG;
            end
            S_AVG: begin
                w_ctrl.avg_en = 1'b1;
                n_state       = S_MERGE;
            end
            S_MERGE: begin
                if (w_commit) begin
                    w_ctrl.base_load = w_res.base_load;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr       <= '0;
            r_primed    <= 1'b0;
            r_threshold <= THR_RESET;
        end else begin
            if (w_in_accept) begin
                r_primed <= 1'b1;
                r_ptr    <= (r_ptr == PW'(AVG_DEPTH - 1)) ? '0 : r_ptr + PW'(1);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_threshold <= i_cfg_data;
            end
        end
    end

    for (genvar g = 0; g < AXES; g++) begin : g_lane
        asd_lane #(
            .AVG_DEPTH (AVG_DEPTH)
        ) u_lane (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctrl      (w_ctrl),
            .i_ptr       (r_ptr),
            .i_sample    (w_samples[g]),
            .i_threshold (r_threshold),
            .o_avg       (w_avgs[g]),
            .o_over      (w_over[g]),
            .o_base_zero (w_base_zero[g])
        );
    end

    asd_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_in_accept),
        .i_commit    (w_commit),
        .i_charger   (i_charger_present),
        .i_armed     (i_recording_armed),
        .i_over      (w_over),
        .i_base_zero (w_base_zero),
        .o_res       (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_commit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_avg_x  <= w_avgs[0];
            r_avg_y  <= w_avgs[1];
            r_avg_z  <= w_avgs[2];
            r_motion <= w_res.motion;
            r_lock   <= w_res.lock;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_avg_x           = r_avg_x;
    assign o_avg_y           = r_avg_y;
    assign o_avg_z           = r_avg_z;
    assign o_motion_detected = r_motion;
    assign o_lock_request    = r_lock;

    `ASD_ASSERT_NOW(a_lock_needs_motion, i_clk, i_rst_n,
        o_out_valid, !(o_lock_request && !o_motion_detected), "lock without motion")
    `ASD_ASSERT_NEXT(a_accept_starts_div, i_clk, i_rst_n,
        w_in_accept, r_state == S_DIV, "accepted request did not start")
    `ASD_ASSERT_NEXT(a_commit_fills_out, i_clk, i_rst_n,
        w_commit, o_out_valid, "committed result not presented")
    `ASD_ASSERT_NEXT(a_merge_waits, i_clk, i_rst_n,
        (r_state == S_MERGE) && o_out_valid && i_out_stall, r_state == S_MERGE,
        "merge left while output blocked")

endmodule

FILE: tb/accel_shock_detector_tb.sv
// Self-checking testbench for the accelerometer shock detector
module accel_shock_detector_tb
    import asd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING_DEPTH = 4;
    localparam int IDLE_PCT   = 20;
    localparam int HANG_LIMIT = 4000;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] x;
        logic signed [SAMPLE_W-1:0] y;
        logic signed [SAMPLE_W-1:0] z;
        logic                       charging;
        logic                       armed;
    } t_sample;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] avg_x;
        logic signed [SAMPLE_W-1:0] avg_y;
        logic signed [SAMPLE_W-1:0] avg_z;
        logic                       motion;
        logic                       lock;
    } t_shock_result;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_stall;
    logic signed [SAMPLE_W-1:0] i_accel_x = '0;
    logic signed [SAMPLE_W-1:0] i_accel_y = '0;
    logic signed [SAMPLE_W-1:0] i_accel_z = '0;
    logic                       i_charger_present = 1'b0;
    logic                       i_recording_armed = 1'b0;
    logic                       o_out_valid;
    logic                       i_out_stall = 1'b0;
    logic signed [SAMPLE_W-1:0] o_avg_x;
    logic signed [SAMPLE_W-1:0] o_avg_y;
    logic signed [SAMPLE_W-1:0] o_avg_z;
    logic                       o_motion_detected;
    logic                       o_lock_request;
    logic                       i_cfg_valid = 1'b0;
    logic                       o_cfg_ready;
    logic [THR_W-1:0]           i_cfg_data = '0;

    t_sample       sample_queue[$];
    t_shock_result expected_results[$];
    t_sample       current_sample;
    int            outstanding = 0;
    int            errors = 0;
    int            quiet_cycles = 0;
    bit            calm = 1'b0;

    // shadow state of the detector
    logic signed [SAMPLE_W-1:0] ring [3][RING_DEPTH];
    int                         ring_ptr = 0;
    bit                         primed = 1'b0;
    int                         baseline [3] = '{0, 0, 0};
    bit                         charger_prev = 1'b0;
    bit                         skip_pending = 1'b0;
    logic [THR_W-1:0]           threshold = THR_RESET;
    int                         level [3] = '{0, 0, 0};

    accel_shock_detector #(
        .AVG_DEPTH(RING_DEPTH)
    ) i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_accel_x        (i_accel_x),
        .i_accel_y        (i_accel_y),
        .i_accel_z        (i_accel_z),
        .i_charger_present(i_charger_present),
        .i_recording_armed(i_recording_armed),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_avg_x          (o_avg_x),
        .o_avg_y          (o_avg_y),
        .o_avg_z          (o_avg_z),
        .o_motion_detected(o_motion_detected),
        .o_lock_request   (o_lock_request),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    function automatic bit exceeds(int base, int avg);
        int d;
        d = base - avg;
        if (d < 0) begin
            d = -d;
        end
        return d > int'(threshold);
    endfunction

    function automatic t_shock_result predict_motion(t_sample s);
        t_shock_result r;
        logic signed [SAMPLE_W-1:0] axis [3];
        int avg [3];
        int sum;
        int count;
        bit reject;
        axis = '{s.x, s.y, s.z};
        if (s.charging != charger_prev) begin
            charger_prev = s.charging;
            skip_pending = 1'b1;
        end
        if (!primed) begin
            for (int a = 0; a < 3; a++) begin
                for (int k = 0; k < RING_DEPTH; k++) begin
                    ring[a][k] = axis[a];
                end
            end
            primed = 1'b1;
        end
        for (int a = 0; a < 3; a++) begin
            ring[a][ring_ptr] = axis[a];
        end
        ring_ptr = (ring_ptr + 1) % RING_DEPTH;
        for (int a = 0; a < 3; a++) begin
            sum = 0;
            for (int k = 0; k < RING_DEPTH; k++) begin
                sum += int'(ring[a][k]);
            end
            avg[a] = sum / RING_DEPTH;
        end
        r.motion = 1'b0;
        r.lock   = 1'b0;
        if (baseline[0] == 0 || baseline[1] == 0 || baseline[2] == 0) begin
            baseline = avg;
        end else begin
            count  = 0;
            reject = 1'b0;
            if (exceeds(baseline[0], avg[0])) begin
                count++;
            end
            if (exceeds(baseline[1], avg[1])) begin
                count++;
            end
            if (exceeds(baseline[2], avg[2])) begin
                count++;
                if (count < int'(COUNT_ALL)) begin
                    reject = 1'b1;
                end
            end
            if (!reject) begin
                baseline = avg;
                if (count >= 1) begin
                    r.motion = 1'b1;
                    if (s.armed) begin
                        if (skip_pending) begin
                            skip_pending = 1'b0;
                        end else begin
                            r.lock = 1'b1;
                        end
                    end
                end
            end
        end
        r.avg_x = avg[0][SAMPLE_W-1:0];
        r.avg_y = avg[1][SAMPLE_W-1:0];
        r.avg_z = avg[2][SAMPLE_W-1:0];
        return r;
    endfunction

    function automatic int clamp16(int v);
        if (v > 32767) begin
            return 32767;
        end
        if (v < -32768) begin
            return -32768;
        end
        return v;
    endfunction

    // driver: present queued samples, idling at random
    always @(posedge i_clk) begin
        bit go;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            go = i_in_valid;
            if (i_in_valid && !o_in_stall) begin
                expected_results.push_back(predict_motion(current_sample));
                go = 1'b0;
            end
            if (!go && sample_queue.size() != 0
                    && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
                current_sample = sample_queue.pop_front();
                outstanding++;
                go = 1'b1;
                i_accel_x         <= current_sample.x;
                i_accel_y         <= current_sample.y;
                i_accel_z         <= current_sample.z;
                i_charger_present <= current_sample.charging;
                i_recording_armed <= current_sample.armed;
            end
            i_in_valid <= go;
        end
    end

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // monitor: check each result against the oldest prediction
    always @(posedge i_clk) begin
        t_shock_result want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %0d/%0d/%0d %b%b",
                             $time, o_avg_x, o_avg_y, o_avg_z, o_motion_detected,
                             o_lock_request);
                    errors++;
                end else begin
                    want = expected_results.pop_front();
                    outstanding--;
                    compare_field("avg_x", want.avg_x, o_avg_x);
                    compare_field("avg_y", want.avg_y, o_avg_y);
                    compare_field("avg_z", want.avg_z, o_avg_z);
                    compare_field("motion_detected", want.motion, o_motion_detected);
                    compare_field("lock_request", want.lock, o_lock_request);
                end
            end
            i_out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= HANG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic push_sample(input int x, input int y, input int z,
                               input bit charging, input bit armed);
        t_sample s;
        s.x        = x[SAMPLE_W-1:0];
        s.y        = y[SAMPLE_W-1:0];
        s.z        = z[SAMPLE_W-1:0];
        s.charging = charging;
        s.armed    = armed;
        sample_queue.push_back(s);
    endtask

    task automatic wait_idle();
        do @(posedge i_clk); while (sample_queue.size() != 0 || outstanding != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_threshold(input logic [THR_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        threshold = value;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // mostly settled motion with random jumps per axis, some pure noise
    task automatic push_random(input int n);
        int delta;
        int noise;
        int v [3];
        bit charging;
        charging = charger_prev;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) < 5) begin
                charging = !charging;
            end
            if ($urandom_range(0, 99) < 10) begin
                for (int a = 0; a < 3; a++) begin
                    v[a] = int'($signed(16'($urandom)));
                end
            end else begin
                if ($urandom_range(0, 99) < 2) begin
                    level = '{0, 0, 0};
                end
                noise = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(0, 8);
                for (int a = 0; a < 3; a++) begin
                    if ($urandom_range(0, 99) < 3) begin
                        level[a] = int'($signed(16'($urandom)));
                    end else if ($urandom_range(0, 99) < 25) begin
                        delta = $urandom_range(0, 8 * int'(threshold) + 300);
                        level[a] = clamp16($urandom_range(0, 1) ? level[a] + delta
                                                               : level[a] - delta);
                    end
                    v[a] = clamp16(level[a] + int'($urandom_range(0, 2 * noise)) - noise);
                end
            end
            push_sample(v[0], v[1], v[2], charging, $urandom_range(0, 99) < 80);
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // prime, single axes, count rule, charger edges, extremes, zero baseline
        push_sample(1000, 2000, 3000, 0, 1);
        push_sample(1000, 2000, 3000, 0, 1);
        push_sample(1400, 2000, 3000, 0, 1);
        push_sample(1400, 2400, 3000, 1, 1);
        push_sample(1400, 2400, 3400, 1, 1);
        push_sample(1800, 2400, 3800, 1, 1);
        push_sample(2600, 3200, 4600, 0, 1);
        push_sample(2600, 3200, 4600, 0, 0);
        push_sample(-4000, -4000, -4000, 0, 0);
        push_sample(-4000, -4000, -4000, 0, 1);
        push_sample(32767, 32767, 32767, 1, 1);
        push_sample(32767, 32767, 32767, 1, 1);
        for (int i = 0; i < 4; i++) begin
            push_sample(-32768, -32768, -32768, 0, 1);
        end
        for (int i = 0; i < 4; i++) begin
            push_sample(0, 0, 0, 1, 1);
        end
        push_sample(0, 500, -500, 0, 1);
        push_sample(300, -300, 0, 1, 1);
        push_sample(-1, -1, -1, 0, 1);
        push_sample(21845, -21846, 21845, 1, 0);
        wait_idle();

        set_threshold(8'd0);
        push_random(300);
        wait_idle();

        set_threshold(8'd255);
        push_random(300);
        wait_idle();

        calm = 1'b1;
        set_threshold(THR_W'($urandom_range(2, 254)));
        push_random(400);
        wait_idle();
        calm = 1'b0;

        set_threshold(8'd1);
        push_random(350);
        wait_idle();

        set_threshold(8'd128);
        push_random(400);
        wait_idle();

        repeat (8) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            $display("%0t: results missing, expected %0d more, actual 0",
                     $time, expected_results.size());
            errors++;
        end
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl
rtl/asd_pkg.sv
rtl/asd_lane.sv
rtl/asd_merge.sv
rtl/accel_shock_detector.sv
tb/accel_shock_detector_tb.sv
